// File: hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned UNIT_W  = 16;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd80;
    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // raw command codes on the input port
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // engine phases
    localparam logic [PHASE_W-1:0] PH_IDLE_FREE = 5'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE_HELD = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_PRE    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_A      = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST_B1     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ST_B2     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_ST_C1     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_ST_C2     = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WB_LO     = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WB_HI     = 5'd9;
    localparam logic [PHASE_W-1:0] PH_WA_LO     = 5'd10;
    localparam logic [PHASE_W-1:0] PH_WA_HI     = 5'd11;
    localparam logic [PHASE_W-1:0] PH_WA_TAIL   = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RB_LO     = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RB_HI     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RA_LO     = 5'd15;
    localparam logic [PHASE_W-1:0] PH_RA_HI     = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RA_TAIL   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_SP_A      = 5'd18;
    localparam logic [PHASE_W-1:0] PH_SP_B      = 5'd19;
    localparam logic [PHASE_W-1:0] PH_SP_C      = 5'd20;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_WRITE,
        OP_READ,
        OP_STOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] payload;
        logic       last;
        logic       sda;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic       nack;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic scl;
        logic sda_out;
        logic sda_drive;
    } pins_t;

    // bus levels per phase; released sda reads as high
    function automatic pins_t phase_pins(input logic [PHASE_W-1:0] phase,
                                         input logic msb, input logic final_byte);
        pins_t p;
        p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0};
        case (phase)
            PH_IDLE_FREE: p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b0};
            PH_IDLE_HELD: p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0};
            PH_ST_PRE:    p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b1};
            PH_ST_A:      p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1};
            PH_ST_B1:     p = '{scl: 1'b1, sda_out: 1'b0, sda_drive: 1'b1};
            PH_ST_B2:     p = '{scl: 1'b1, sda_out: 1'b0, sda_drive: 1'b1};
            PH_ST_C1:     p = '{scl: 1'b0, sda_out: 1'b0, sda_drive: 1'b1};
            PH_ST_C2:     p = '{scl: 1'b0, sda_out: 1'b0, sda_drive: 1'b1};
            PH_WB_LO:     p = '{scl: 1'b0, sda_out: msb, sda_drive: 1'b1};
            PH_WB_HI:     p = '{scl: 1'b1, sda_out: msb, sda_drive: 1'b1};
            PH_WA_LO:     p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0};
            PH_WA_HI:     p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b0};
            PH_WA_TAIL:   p = '{scl: 1'b0, sda_out: 1'b0, sda_drive: 1'b1};
            PH_RB_LO:     p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0};
            PH_RB_HI:     p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b0};
            PH_RA_LO:     p = '{scl: 1'b0, sda_out: final_byte, sda_drive: 1'b1};
            PH_RA_HI:     p = '{scl: 1'b1, sda_out: final_byte, sda_drive: 1'b1};
            PH_RA_TAIL:   p = '{scl: 1'b0, sda_out: 1'b1, sda_drive: 1'b0};
            PH_SP_A:      p = '{scl: 1'b0, sda_out: 1'b0, sda_drive: 1'b1};
            PH_SP_B:      p = '{scl: 1'b1, sda_out: 1'b0, sda_drive: 1'b1};
            PH_SP_C:      p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1};
            default:      p = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b0};
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/i2cm_fifo.sv
`timescale 1ns / 1ps

module i2cm_fifo #(
    parameter int unsigned W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("fifo count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("fifo count missed a push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("fifo pointers disagree with count");

endmodule

// File: hw/rtl/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [2:0]      command,
    input  logic [6:0]      address,
    input  logic            read_mode,
    input  logic [7:0]      data,
    input  logic            last,
    input  logic            sda_in,
    input  logic            item_pop,
    output i2cm_pkg::item_t item,
    output logic            item_empty
);

    import i2cm_pkg::*;

    item_t decoded;
    op_t   op;

    // unknown codes become no-ops here so the engine never sees them
    always_comb
    begin
        unique case (command)
            CMD_START: op = OP_START;
            CMD_WRITE: op = OP_WRITE;
            CMD_READ:  op = OP_READ;
            CMD_STOP:  op = OP_STOP;
            default:   op = OP_NONE;
        endcase
        decoded.op      = op;
        decoded.payload = (op == OP_START) ? {address, read_mode} : data;
        decoded.last    = last;
        decoded.sda     = sda_in;
    end

    i2cm_fifo #(
        .W ($bits(item_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (decoded),
        .full  (full),
        .pop   (item_pop),
        .rdata (item),
        .empty (item_empty)
    );

endmodule

// File: hw/rtl/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [i2cm_pkg::UNIT_W-1:0]      unit_ticks,
    input  i2cm_pkg::item_t                  item,
    input  logic                             item_empty,
    output logic                             item_pop,
    input  logic                             res_pop,
    output i2cm_pkg::result_t                res,
    output logic                             res_empty
);

    import i2cm_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [3:0]         bit_index_reg;
    logic [3:0]         bit_index_next;
    logic [7:0]         shifter_reg;
    logic [7:0]         shifter_next;
    logic [UNIT_W-1:0]  tick_count_reg;
    logic [UNIT_W-1:0]  tick_count_next;
    logic               nack_flag_reg;
    logic               nack_flag_next;
    logic               final_byte_reg;
    logic               final_byte_next;
    logic [7:0]         received_reg;
    logic [7:0]         received_next;

    logic               res_full;
    logic               take;
    logic               idle;
    logic               held;
    logic               done;
    logic [UNIT_W-1:0]  unit;
    logic               seg_end;
    logic [3:0]         bit_inc;
    pins_t              pins;
    result_t            result;

    assign take     = !item_empty && !res_full;
    assign item_pop = take;
    assign idle     = (phase_reg == PH_IDLE_FREE) || (phase_reg == PH_IDLE_HELD);
    assign held     = (phase_reg == PH_IDLE_HELD);
    assign unit     = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
    assign seg_end  = ({1'b0, tick_count_reg} + 17'd1) >= {1'b0, unit};
    assign bit_inc  = bit_index_reg + 4'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shifter_next    = shifter_reg;
        tick_count_next = tick_count_reg;
        nack_flag_next  = nack_flag_reg;
        final_byte_next = final_byte_reg;
        received_next   = received_reg;
        done            = 1'b0;

        if (idle)
        begin
            unique case (item.op)
                OP_START:
                begin
                    shifter_next    = item.payload;
                    bit_index_next  = '0;
                    tick_count_next = '0;
                    phase_next      = held ? PH_ST_PRE : PH_ST_A;
                end
                OP_WRITE:
                begin
                    if (held)
                    begin
                        shifter_next    = item.payload;
                        bit_index_next  = '0;
                        tick_count_next = '0;
                        phase_next      = PH_WB_LO;
                    end
                end
                OP_READ:
                begin
                    if (held)
                    begin
                        shifter_next    = '0;
                        bit_index_next  = '0;
                        final_byte_next = item.last;
                        tick_count_next = '0;
                        phase_next      = PH_RB_LO;
                    end
                end
                OP_STOP:
                begin
                    if (held)
                    begin
                        tick_count_next = '0;
                        phase_next      = PH_SP_A;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (seg_end)
        begin
            tick_count_next = '0;
            case (phase_reg)
                PH_ST_PRE: phase_next = PH_ST_A;
                PH_ST_A:   phase_next = PH_ST_B1;
                PH_ST_B1:  phase_next = PH_ST_B2;
                PH_ST_B2:  phase_next = PH_ST_C1;
                PH_ST_C1:  phase_next = PH_ST_C2;
                PH_ST_C2:  phase_next = PH_WB_LO;
                PH_WB_LO:  phase_next = PH_WB_HI;
                PH_WB_HI:
                begin
                    shifter_next   = {shifter_reg[6:0], 1'b0};
                    bit_index_next = bit_inc;
                    phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_WA_LO : PH_WB_LO;
                end
                PH_WA_LO:  phase_next = PH_WA_HI;
                PH_WA_HI:
                begin
                    // slave ack sampled at the end of the high segment
                    nack_flag_next = item.sda;
                    phase_next     = PH_WA_TAIL;
                end
                PH_WA_TAIL:
                begin
                    if (nack_flag_reg)
                    begin
                        phase_next = PH_SP_A;
                    end
                    else
                    begin
                        phase_next = PH_IDLE_HELD;
                        done       = 1'b1;
                    end
                end
                PH_RB_LO:  phase_next = PH_RB_HI;
                PH_RB_HI:
                begin
                    shifter_next   = {shifter_reg[6:0], item.sda};
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        received_next = {shifter_reg[6:0], item.sda};
                        phase_next    = PH_RA_LO;
                    end
                    else
                    begin
                        phase_next = PH_RB_LO;
                    end
                end
                PH_RA_LO:  phase_next = PH_RA_HI;
                PH_RA_HI:  phase_next = PH_RA_TAIL;
                PH_RA_TAIL:
                begin
                    phase_next = PH_IDLE_HELD;
                    done       = 1'b1;
                end
                PH_SP_A:   phase_next = PH_SP_B;
                PH_SP_B:   phase_next = PH_SP_C;
                PH_SP_C:
                begin
                    phase_next = PH_IDLE_FREE;
                    done       = 1'b1;
                end
                default:   phase_next = PH_IDLE_FREE;
            endcase
        end
        else
        begin
            tick_count_next = tick_count_reg + UNIT_W'(1);
        end

        pins = phase_pins(phase_next, |(shifter_next & MSB_MASK), final_byte_next);
        result.scl       = pins.scl;
        result.sda_out   = pins.sda_out;
        result.sda_drive = pins.sda_drive;
        result.busy      = (phase_next != PH_IDLE_FREE) && (phase_next != PH_IDLE_HELD);
        result.done      = done;
        result.nack      = nack_flag_next;
        result.read_data = received_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE_FREE;
            bit_index_reg  <= '0;
            shifter_reg    <= '0;
            tick_count_reg <= '0;
            nack_flag_reg  <= 1'b0;
            final_byte_reg <= 1'b0;
            received_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shifter_reg    <= shifter_next;
            tick_count_reg <= tick_count_next;
            nack_flag_reg  <= nack_flag_next;
            final_byte_reg <= final_byte_next;
            received_reg   <= received_next;
        end
    end

    i2cm_fifo #(
        .W ($bits(result_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .wdata (result),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res),
        .empty (res_empty)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && done) |=> (phase_reg == PH_IDLE_FREE || phase_reg == PH_IDLE_HELD))
        else $error("done without returning to idle");
    assert property (@(posedge clk) disable iff (!rst_n) bit_index_reg <= BITS_PER_BYTE)
        else $error("bit index past one byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WA_LO || phase_reg == PH_RA_LO) |-> (bit_index_reg == BITS_PER_BYTE))
        else $error("ack phase entered before eight bits");

endmodule

// File: hw/rtl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps

// i2c master bit engine
// input queue: push/full. each transaction is one timebase tick carrying an
// optional command (start, write, read, stop) and the sampled sda level.
// result queue: empty/pop. exactly one result per input tick, in order, with
// the scl/sda levels, busy, a one-tick done pulse, the nack flag and the
// last received byte.
// config channel: cfg_valid/cfg_ready/cfg_data writes unit_ticks (ticks per
// bus timing segment, 0 behaves as 1); cfg_ready is always high.
// a pushed tick is registered in the decode queue, then the engine writes its
// result into the result queue, from which it can be popped.
// throughput: one tick per cycle while the result queue has room.
// each side has a 2-entry queue, so a stalled consumer fills the result
// queue, then the engine holds, then full rises; a push while full is ignored.
// reset: engine in the bus-free phase (scl high, sda released), unit_ticks 80, queues empty.

module i2c_master_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [6:0]  address,
    input  logic        read_mode,
    input  logic [7:0]  data,
    input  logic        last,
    input  logic        sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        scl,
    output logic        sda_out,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic        nack,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    import i2cm_pkg::*;

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic [UNIT_W-1:0] unit_ticks_next;
    item_t             item;
    logic              item_empty;
    logic              item_pop;
    result_t           res;

    assign cfg_ready       = 1'b1;
    assign unit_ticks_next = (cfg_valid && cfg_ready) ? cfg_data : unit_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_RESET;
        end
        else
        begin
            unit_ticks_reg <= unit_ticks_next;
        end
    end

    i2cm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .address    (address),
        .read_mode  (read_mode),
        .data       (data),
        .last       (last),
        .sda_in     (sda_in),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    i2cm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_ticks (unit_ticks_reg),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .res_pop    (pop),
        .res        (res),
        .res_empty  (empty)
    );

    assign scl       = res.scl;
    assign sda_out   = res.sda_out;
    assign sda_drive = res.sda_drive;
    assign busy_res  = res.busy;
    assign done_res  = res.done;
    assign nack      = res.nack;
    assign read_data = res.read_data;

endmodule
